// ===== rtl/core/wav_riff_pcm_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef WAV_RIFF_PCM_DEFRAMER_MACROS_SVH
`define WAV_RIFF_PCM_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define WRPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wrpd assertion failed");
`define WRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wrpd assertion failed");
`else
`define WRPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/wrpd_pkg.sv =====
// Types and constants of the RIFF/WAVE PCM deframer.
package wrpd_pkg;

    localparam logic [5:0]  MIN_FILE  = 6'd44;
    localparam logic [31:0] RIFF_TEXT = 32'h52494646;
    localparam logic [31:0] WAVE_TEXT = 32'h57415645;
    localparam logic [31:0] TAG_FMT   = 32'h666D7420;
    localparam logic [31:0] TAG_DATA  = 32'h64617461;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [2:0] ERR_SHORT   = 3'd0;
    localparam logic [2:0] ERR_TAGS    = 3'd1;
    localparam logic [2:0] ERR_MISSING = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM = 3'd3;
    localparam logic [2:0] ERR_BITS    = 3'd4;
    localparam logic [2:0] ERR_NONE    = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_wrpd_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] sample;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [15:0]        sample_bits;
        logic [2:0]         error_code;
        logic               final_res;
    } t_wrpd_out;

endpackage

// ===== rtl/core/wav_riff_pcm_deframer.sv =====
// Byte-wide RIFF/WAVE parser that emits the format report, Q1.31 PCM samples and error or end reports.
// An accepted byte is held in the input register, and its result beat is registered in the output register.
// Throughput: one byte per cycle while the result is not stalled; the per-byte parse state update is combinational.
// A stalled result holds the input register; intake stops once that register is full.
// Reset: synchronous, active low; clears parse state and both valid flags.
// The final byte of a file also returns the parse state to its reset values.
`include "wav_riff_pcm_deframer_macros.svh"

module wav_riff_pcm_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wrpd_pkg::t_wrpd_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wrpd_pkg::t_wrpd_out o_out_data
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK,
        PH_FMT,
        PH_SKIP,
        PH_PAD,
        PH_DATA,
        PH_DONE,
        PH_FAILED
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [5:0]          r_byte_total, n_byte_total;
    logic [31:0]         r_chunk_tag, n_chunk_tag;
    logic [31:0]         r_chunk_length, n_chunk_length;
    logic [31:0]         r_bytes_left, n_bytes_left;
    logic                r_odd_pad, n_odd_pad;
    logic [15:0]         r_format_tag, n_format_tag;
    logic [15:0]         r_channels, n_channels;
    logic [31:0]         r_rate, n_rate;
    logic [15:0]         r_bits, n_bits;
    logic                r_fmt_found, n_fmt_found;
    logic [4:0]          r_fmt_pos, n_fmt_pos;
    logic [31:0]         r_gather, n_gather;
    logic [1:0]          r_gather_cnt, n_gather_cnt;
    logic [2:0]          r_pending, n_pending;

    logic                r_in_vld;
    wrpd_pkg::t_wrpd_in  r_in;
    logic                r_out_vld;
    wrpd_pkg::t_wrpd_out r_out, n_out;

    logic                in_acc;
    logic                adv;
    logic [7:0]          b;
    logic                res_vld;
    logic [1:0]          res_kind;
    logic [31:0]         res_smp;
    logic [2:0]          res_err;
    logic [31:0]         full_len;
    logic [31:0]         full_smp;
    logic [31:0]         dec_left;

    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign b          = r_in.data_byte;
    assign full_len   = {b, r_chunk_length[23:0]};
    assign dec_left   = r_bytes_left - 32'd1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        full_smp = r_gather;
        full_smp[8*r_gather_cnt +: 8] = b;
    end

    always_comb begin
        n_phase        = r_phase;
        n_byte_total   = r_byte_total;
        n_chunk_tag    = r_chunk_tag;
        n_chunk_length = r_chunk_length;
        n_bytes_left   = r_bytes_left;
        n_odd_pad      = r_odd_pad;
        n_format_tag   = r_format_tag;
        n_channels     = r_channels;
        n_rate         = r_rate;
        n_bits         = r_bits;
        n_fmt_found    = r_fmt_found;
        n_fmt_pos      = r_fmt_pos;
        n_gather       = r_gather;
        n_gather_cnt   = r_gather_cnt;
        n_pending      = r_pending;
        res_vld        = 1'b0;
        res_kind       = wrpd_pkg::KIND_FORMAT;
        res_smp        = '0;
        res_err        = wrpd_pkg::ERR_SHORT;

        if (r_byte_total < wrpd_pkg::MIN_FILE) begin
            n_byte_total = r_byte_total + 6'd1;
        end

        unique case (r_phase)
            PH_HEADER: begin
                if (r_byte_total < 6'd4 &&
                    b != wrpd_pkg::RIFF_TEXT[8*(2'd3 - r_byte_total[1:0]) +: 8]) begin
                    n_pending = wrpd_pkg::ERR_TAGS;
                end
                if (r_byte_total >= 6'd8 && r_byte_total < 6'd12 &&
                    b != wrpd_pkg::WAVE_TEXT[8*(2'd3 - r_byte_total[1:0]) +: 8]) begin
                    n_pending = wrpd_pkg::ERR_TAGS;
                end
                if (r_byte_total >= 6'd11) begin
                    n_phase      = (n_pending != wrpd_pkg::ERR_NONE) ? PH_FAILED : PH_CHUNK;
                    n_bytes_left = '0;
                end
            end
            PH_CHUNK: begin
                if (r_bytes_left[2:0] == 3'd0) begin
                    n_chunk_tag    = {24'h0, b};
                    n_chunk_length = '0;
                end else if (!r_bytes_left[2]) begin
                    n_chunk_tag = {r_chunk_tag[23:0], b};
                end else begin
                    n_chunk_length[8*r_bytes_left[1:0] +: 8] = b;
                end
                n_bytes_left = {29'h0, r_bytes_left[2:0] + 3'd1};
                if (r_bytes_left[2:0] == 3'd7) begin
                    n_odd_pad    = full_len[0];
                    n_bytes_left = full_len;
                    if (r_chunk_tag == wrpd_pkg::TAG_DATA) begin
                        if (!r_fmt_found) begin
                            n_pending = wrpd_pkg::ERR_MISSING;
                        end else if (r_format_tag != 16'd1) begin
                            n_pending = wrpd_pkg::ERR_NOT_PCM;
                        end else if (r_bits != 16'd16 && r_bits != 16'd24 &&
                                     r_bits != 16'd32) begin
                            n_pending = wrpd_pkg::ERR_BITS;
                        end
                        if (n_pending != wrpd_pkg::ERR_NONE) begin
                            n_phase = PH_FAILED;
                        end else begin
                            res_vld      = 1'b1;
                            res_kind     = wrpd_pkg::KIND_FORMAT;
                            n_gather     = '0;
                            n_gather_cnt = '0;
                            n_phase      = (full_len != 32'd0) ? PH_DATA : PH_DONE;
                        end
                    end else if (r_chunk_tag == wrpd_pkg::TAG_FMT && full_len >= 32'd16) begin
                        n_fmt_found = 1'b1;
                        n_fmt_pos   = '0;
                        n_phase     = PH_FMT;
                    end else if (full_len == 32'd0) begin
                        n_bytes_left = '0;
                        n_phase      = PH_CHUNK;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                case (r_fmt_pos) inside
                    5'd0:          n_format_tag[7:0]  = b;
                    5'd1:          n_format_tag[15:8] = b;
                    5'd2:          n_channels[7:0]    = b;
                    5'd3:          n_channels[15:8]   = b;
                    [5'd4:5'd7]:   n_rate[8*r_fmt_pos[1:0] +: 8] = b;
                    5'd14:         n_bits[7:0]        = b;
                    5'd15:         n_bits[15:8]       = b;
                    default: begin
                    end
                endcase
                if (r_fmt_pos < 5'd16) begin
                    n_fmt_pos = r_fmt_pos + 5'd1;
                end
                n_bytes_left = dec_left;
                if (dec_left == 32'd0) begin
                    n_phase = r_odd_pad ? PH_PAD : PH_CHUNK;
                end
            end
            PH_SKIP: begin
                n_bytes_left = dec_left;
                if (dec_left == 32'd0) begin
                    n_phase = r_odd_pad ? PH_PAD : PH_CHUNK;
                end
            end
            PH_PAD: begin
                n_phase      = PH_CHUNK;
                n_bytes_left = '0;
            end
            PH_DATA: begin
                n_gather     = full_smp;
                n_gather_cnt = r_gather_cnt + 2'd1;
                if (n_gather_cnt == r_bits[4:3]) begin
                    res_vld  = 1'b1;
                    res_kind = wrpd_pkg::KIND_SAMPLE;
                    if (r_bits[4:3] == 2'd2) begin
                        res_smp = {full_smp[15:0], 16'h0};
                    end else if (r_bits[4:3] == 2'd3) begin
                        res_smp = {full_smp[23:0], 8'h0};
                    end else begin
                        res_smp = full_smp;
                    end
                    n_gather     = '0;
                    n_gather_cnt = '0;
                end
                n_bytes_left = dec_left;
                if (dec_left == 32'd0) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE, PH_FAILED: begin
            end
        endcase

        if (r_in.end_of_file) begin
            if (n_byte_total < wrpd_pkg::MIN_FILE) begin
                res_vld  = 1'b1;
                res_kind = wrpd_pkg::KIND_ERROR;
                res_err  = wrpd_pkg::ERR_SHORT;
                res_smp  = '0;
            end else if (!res_vld) begin
                res_vld = 1'b1;
                if (n_pending != wrpd_pkg::ERR_NONE) begin
                    res_kind = wrpd_pkg::KIND_ERROR;
                    res_err  = n_pending;
                end else if (n_phase == PH_DATA || n_phase == PH_DONE) begin
                    res_kind = wrpd_pkg::KIND_END;
                end else begin
                    res_kind = wrpd_pkg::KIND_ERROR;
                    res_err  = wrpd_pkg::ERR_MISSING;
                end
            end
        end

        n_out.kind          = res_kind;
        n_out.sample        = (res_kind == wrpd_pkg::KIND_SAMPLE) ? res_smp : '0;
        n_out.channel_count = n_channels;
        n_out.sample_rate   = n_rate;
        n_out.sample_bits   = n_bits;
        n_out.error_code    = (res_kind == wrpd_pkg::KIND_ERROR) ? res_err : '0;
        n_out.final_res     = r_in.end_of_file;

        if (r_in.end_of_file) begin
            n_phase        = PH_HEADER;
            n_byte_total   = '0;
            n_chunk_tag    = '0;
            n_chunk_length = '0;
            n_bytes_left   = '0;
            n_odd_pad      = 1'b0;
            n_format_tag   = '0;
            n_channels     = '0;
            n_rate         = '0;
            n_bits         = '0;
            n_fmt_found    = 1'b0;
            n_fmt_pos      = '0;
            n_gather       = '0;
            n_gather_cnt   = '0;
            n_pending      = wrpd_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_byte_total   <= '0;
            r_chunk_tag    <= '0;
            r_chunk_length <= '0;
            r_bytes_left   <= '0;
            r_odd_pad      <= 1'b0;
            r_format_tag   <= '0;
            r_channels     <= '0;
            r_rate         <= '0;
            r_bits         <= '0;
            r_fmt_found    <= 1'b0;
            r_fmt_pos      <= '0;
            r_gather       <= '0;
            r_gather_cnt   <= '0;
            r_pending      <= wrpd_pkg::ERR_NONE;
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv && res_vld) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (adv) begin
                r_phase        <= n_phase;
                r_byte_total   <= n_byte_total;
                r_chunk_tag    <= n_chunk_tag;
                r_chunk_length <= n_chunk_length;
                r_bytes_left   <= n_bytes_left;
                r_odd_pad      <= n_odd_pad;
                r_format_tag   <= n_format_tag;
                r_channels     <= n_channels;
                r_rate         <= n_rate;
                r_bits         <= n_bits;
                r_fmt_found    <= n_fmt_found;
                r_fmt_pos      <= n_fmt_pos;
                r_gather       <= n_gather;
                r_gather_cnt   <= n_gather_cnt;
                r_pending      <= n_pending;
            end
        end
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (adv && res_vld) begin
            r_out <= n_out;
        end
    end

    `WRPD_ASSERT_IMPLY(a_err_code_only_on_error, i_clk, i_rst_n, o_out_valid && o_out_data.kind != wrpd_pkg::KIND_ERROR, o_out_data.error_code == wrpd_pkg::ERR_SHORT)
    `WRPD_ASSERT_NEXT(a_final_byte_resets, i_clk, i_rst_n, adv && r_in.end_of_file, r_phase == PH_HEADER && r_byte_total == 6'd0)
    `WRPD_ASSERT_IMPLY(a_data_needs_fmt, i_clk, i_rst_n, r_phase == PH_DATA, r_fmt_found && r_pending == wrpd_pkg::ERR_NONE)
    `WRPD_ASSERT_IMPLY(a_failed_has_error, i_clk, i_rst_n, r_phase == PH_FAILED, r_pending != wrpd_pkg::ERR_NONE)

endmodule
